// ===== rtl/core/ridp_pkg.sv =====
// Shared types and constants for the row image to display page packer.
// Depends on nothing; imported by the top level and ridp_merge.
package ridp_pkg;

	// Widest pixel group the datapath is built around (bytes per item)
	localparam int MAX_LANES = 8;

	// Register indexes, decoded from paddr[2]
	localparam logic REG_COLUMN_COUNT = 1'b0;
	localparam logic REG_ROW_COUNT    = 1'b1;

	// Register reset values
	localparam logic [7:0] COLUMN_COUNT_RESET = 8'd128;
	localparam logic [6:0] ROW_COUNT_RESET    = 7'd64;

	// Set-position command bytes
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [3:0] CMD_BYTES     = 4'd3;

	// Control handed to the merge stage for one read-modify-write
	typedef struct packed {
		logic [2:0]           row_bit;   // bit of each column byte this row owns
		logic                 first_row; // first row of a page: clear whole bytes
		logic [MAX_LANES-1:0] lane_live; // lane lies inside the image width
	} merge_ctl_t;

endpackage

// ===== rtl/core/row_image_to_display_pages_top.sv =====
// Top level of the row image to display page packer: control, config port, output register.
// Depends on ridp_pkg, ridp_ram and ridp_merge.
//
// Takes a row-major image, PIXELS_PER_ITEM byte pixels per request (zero byte = lit), and
// builds display pages in a page store of ceil(MAX_COLUMNS / PIXELS_PER_ITEM) entries.
// Each pixel request reads its store entry when it is accepted, then merges the group
// into it and writes it back in ST_MERGE. After the last group of a page's eighth
// row, or of the image's last row, the block emits a set-position command request
// (0xB0+page, 0x10, 0x00) and then one data request per group; each data request is
// a store read (ST_READ), then a load into the output register (ST_DATA). The input
// is held off until the page's last data request is loaded, output stalls included.
// Writing either register restarts the image at row 0. Every store entry is rewritten
// on the first row of a page before it is read out, so no clearing pass follows reset.
module row_image_to_display_pages_top import ridp_pkg::*; #(
	parameter int MAX_COLUMNS     = 128,
	parameter int MAX_ROWS        = 64,
	parameter int PIXELS_PER_ITEM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Pixel input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] pixel_group,
	// Page output
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_command,
	output logic [63:0] payload,
	output logic [3:0]  byte_count,
	output logic        last_of_page
);

	localparam int STORE_DEPTH = (MAX_COLUMNS + PIXELS_PER_ITEM - 1) / PIXELS_PER_ITEM;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int BW          = $clog2(MAX_COLUMNS + PIXELS_PER_ITEM + 1);
	localparam int RW          = $clog2(MAX_ROWS + 1);
	localparam int RIW         = $clog2(MAX_ROWS);
	localparam int EW          = PIXELS_PER_ITEM * 8;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MERGE = 5'b00010,
		ST_CMD   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_DATA  = 5'b10000
	} state_t;

	state_t          state_q, state_d;
	logic [7:0]      col_q;
	logic [6:0]      rows_q;
	logic [AW-1:0]   group_q;
	logic [BW-1:0]   base_q;
	logic [RIW-1:0]  row_q;
	logic [7:0]      cmd_page_q;
	logic [63:0]     pixel_s1;

	logic            out_valid_q;
	logic            is_command_q;
	logic [63:0]     payload_q;
	logic [3:0]      byte_count_q;
	logic            last_of_page_q;

	logic            cfg_wr;
	logic            in_acc;
	logic            slot_free;
	logic [8:0]      col_w, cols_w;
	logic [BW-1:0]   cols_eff;
	logic [7:0]      rows_w, rows_sat;
	logic [RW-1:0]   rows_eff;
	logic            last_row;
	logic [RIW-1:0]  row_next;
	logic [2:0]      row_bit;
	logic [BW-1:0]   left;
	logic            grp_last;
	logic [3:0]      data_cnt;
	logic            emit_page;
	logic            load_cmd, load_data;
	merge_ctl_t      merge_ctl;
	logic [EW-1:0]   ram_rdata, merged;
	logic            ram_re, ram_we;
	logic [63:0]     rdata_ext, data_payload;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			REG_COLUMN_COUNT: prdata = 32'(col_q);
			REG_ROW_COUNT:    prdata = 32'(rows_q);
			default:          prdata = 32'd0;
		endcase
	end

	// Effective image size: zero reads as one, oversize saturates
	assign col_w    = {1'b0, col_q};
	assign cols_w   = (col_q == 8'd0) ? 9'd1 :
	                  ((col_w > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : col_w);
	assign cols_eff = BW'(cols_w);
	assign rows_w   = {1'b0, rows_q};
	assign rows_sat = (rows_q == 7'd0) ? 8'd1 :
	                  ((rows_w > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : rows_w);
	assign rows_eff = RW'(rows_sat);

	// Row and group position
	assign row_bit   = row_q[2:0];
	assign last_row  = (RW'(row_q) + RW'(1)) == rows_eff;
	assign row_next  = last_row ? '0 : row_q + RIW'(1);
	assign emit_page = (row_bit == 3'd7) || last_row;
	assign left      = cols_eff - base_q;
	assign grp_last  = left <= BW'(PIXELS_PER_ITEM);
	assign data_cnt  = (left < BW'(PIXELS_PER_ITEM)) ? 4'(left) : 4'(PIXELS_PER_ITEM);

	// Handshakes
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_cmd  = (state_q == ST_CMD) && slot_free;
	assign load_data = (state_q == ST_DATA) && slot_free;

	// Merge control
	always_comb begin
		merge_ctl.row_bit   = row_bit;
		merge_ctl.first_row = (row_bit == 3'd0);
		for (int i = 0; i < MAX_LANES; i++) begin
			merge_ctl.lane_live[i] = (i < PIXELS_PER_ITEM) && ((base_q + BW'(i)) < cols_eff);
		end
	end

	// Page store
	assign ram_re = in_acc || (state_q == ST_READ);
	assign ram_we = (state_q == ST_MERGE);

	ridp_ram #(
		.WIDTH (EW),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (group_q),
		.wdata   (merged),
		.re      (ram_re),
		.raddr   (group_q),
		.rdata_q (ram_rdata)
	);

	ridp_merge #(
		.LANES (PIXELS_PER_ITEM)
	) u_merge (
		.ctl       (merge_ctl),
		.pixels    (pixel_s1[EW-1:0]),
		.entry_old (ram_rdata),
		.entry_new (merged)
	);

	// Data item: keep only the bytes inside the image width
	assign rdata_ext = 64'(ram_rdata);
	always_comb begin
		for (int i = 0; i < MAX_LANES; i++) begin
			data_payload[8*i +: 8] = (4'(i) < data_cnt) ? rdata_ext[8*i +: 8] : 8'h00;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_MERGE;
			end
			ST_MERGE: begin
				state_d = (grp_last && emit_page) ? ST_CMD : ST_IDLE;
			end
			ST_CMD: begin
				if (slot_free) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (slot_free) state_d = grp_last ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= COLUMN_COUNT_RESET;
			rows_q  <= ROW_COUNT_RESET;
			group_q <= '0;
			base_q  <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (paddr[2])
					REG_COLUMN_COUNT: col_q  <= pwdata[7:0];
					REG_ROW_COUNT:    rows_q <= pwdata[6:0];
					default: ;
				endcase
				group_q <= '0;
				base_q  <= '0;
				row_q   <= '0;
			end else if ((state_q == ST_MERGE) || load_data) begin
				// Step to the next group, or wrap at the end of the row / page
				if (grp_last) begin
					group_q <= '0;
					base_q  <= '0;
				end else begin
					group_q <= group_q + AW'(1);
					base_q  <= base_q + BW'(PIXELS_PER_ITEM);
				end
				if ((state_q == ST_MERGE) && grp_last) begin
					row_q <= row_next;
				end
			end
		end
	end

	// Pixel and command page hold registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pixel_group;
		end
		if (state_q == ST_MERGE) begin
			cmd_page_q <= CMD_PAGE_BASE + 8'(row_q >> 3);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_cmd || load_data) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_cmd) begin
			is_command_q   <= 1'b1;
			payload_q      <= {40'd0, CMD_COL_LOW, CMD_COL_HIGH, cmd_page_q};
			byte_count_q   <= CMD_BYTES;
			last_of_page_q <= 1'b0;
		end else if (load_data) begin
			is_command_q   <= 1'b0;
			payload_q      <= data_payload;
			byte_count_q   <= data_cnt;
			last_of_page_q <= grp_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_command   = is_command_q;
	assign payload      = payload_q;
	assign byte_count   = byte_count_q;
	assign last_of_page = last_of_page_q;

	// A command request is always followed by a data request of the same page
	a_cmd_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && is_command) |=> !(out_valid && is_command))
		else $error("command request followed by another command");

	// Data requests carry between one and PIXELS_PER_ITEM bytes
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_command) |->
			(byte_count != 4'd0) && (byte_count <= 4'(PIXELS_PER_ITEM)))
		else $error("data request byte count out of range");

	// The end-of-page mark never sits on a command request
	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_command && last_of_page))
		else $error("command request marked last of page");

	// No pixel request is taken while a page is being read out
	a_no_input_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		load_data |-> !in_ready)
		else $error("pixel request accepted during page readout");

endmodule

// ===== rtl/core/ridp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the page store.
module ridp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/ridp_merge.sv =====
// Merges one pixel group into a page store entry for the current row.
// Depends on ridp_pkg (merge_ctl_t).
module ridp_merge import ridp_pkg::*; #(
	parameter int LANES = 8
) (
	input  merge_ctl_t         ctl,
	input  logic [LANES*8-1:0] pixels,
	input  logic [LANES*8-1:0] entry_old,
	output logic [LANES*8-1:0] entry_new
);

	// Per column byte: optional clear, then set or clear this row's bit
	always_comb begin
		entry_new = entry_old;
		for (int i = 0; i < LANES; i++) begin
			if (ctl.first_row) begin
				entry_new[8*i +: 8] = 8'h00;
			end
			entry_new[8*i + int'(ctl.row_bit)] = 1'b0;
			if (ctl.lane_live[i] && (pixels[8*i +: 8] == 8'h00)) begin
				entry_new[8*i + int'(ctl.row_bit)] = 1'b1;
			end
		end
	end

endmodule
